// ----- hw/rtl/per_cell_standard_deviation_top_macros.svh -----
// Assertion macros used by the sequencer RTL of the per-cell deviation block
`ifndef PER_CELL_STANDARD_DEVIATION_TOP_MACROS_SVH
`define PER_CELL_STANDARD_DEVIATION_TOP_MACROS_SVH

// same-cycle implication
`define PCSD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcsd assertion failed");

// next-cycle implication
`define PCSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcsd assertion failed");

`endif

// ----- hw/rtl/pcsd_pkg.sv -----
// ----------------------------------------------------------------------------
// pcsd_pkg
// Types and constants shared by the per-cell deviation controller and datapath.
// ----------------------------------------------------------------------------
package pcsd_pkg;

   localparam int CELLS   = 4096;
   localparam int CELL_W  = $clog2(CELLS);
   localparam int VAL_W   = 32;
   localparam int SUM_W   = 40;
   localparam int CNT_W   = 9;
   localparam int SQ_W    = 64;
   localparam int IDX_W   = 2;

   localparam logic [1:0] OP_SUM  = 2'd0;
   localparam logic [1:0] OP_DEV  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_EMPTY  = 2'd1;
   localparam logic [1:0] STAT_SINGLE = 2'd2;

   localparam logic [IDX_W-1:0] REG_INCLUDE_MISSING = 2'd0;
   localparam logic [IDX_W-1:0] REG_SUBSTITUTE      = 2'd1;
   localparam logic [IDX_W-1:0] REG_OUT_MISSING     = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_DECIDE,
      S_WR_SUM,
      S_DIV,
      S_MEAN,
      S_MUL,
      S_WR_SQ,
      S_SQRT,
      S_OUT
   } state_type;

   typedef struct packed {
      logic clear;
      logic load_req;
      logic mem_rd;
      logic wr_sum;
      logic div_start;
      logic div_step;
      logic mean_load;
      logic mul_load;
      logic wr_sq;
      logic sqrt_start;
      logic sqrt_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       skip;
      logic       cnt_zero;
      logic       cnt_one;
      logic       div_done;
      logic       sqrt_done;
      logic       clear_last;
      logic       rsp_busy;
   } status_type;

endpackage

// ----- hw/rtl/pcsd_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcsd_ctrl
// Sequencer: clearing pass, memory read, sum write, divide, mean, multiply, square root and readout.
// ----------------------------------------------------------------------------
`include "per_cell_standard_deviation_top_macros.svh"

module pcsd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pcsd_pkg::status_type status,
   output pcsd_pkg::cmd_type    cmd
);
   import pcsd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:  if (status.clear_last) state_in = S_IDLE;
         S_IDLE:   if (req_valid) state_in = S_READ;
         S_READ:   state_in = S_DECIDE;
         S_DECIDE: begin
            case (status.op)
               OP_SUM:  state_in = status.skip ? S_IDLE : S_WR_SUM;
               OP_DEV:  state_in = (status.cnt_zero || status.skip) ? S_IDLE : S_DIV;
               OP_READ: state_in = (status.cnt_zero || status.cnt_one) ? S_OUT : S_DIV;
               default: state_in = S_IDLE;
            endcase
         end
         S_WR_SUM: state_in = S_IDLE;
         S_DIV:    if (status.div_done) state_in = (status.op == OP_DEV) ? S_MEAN : S_SQRT;
         S_MEAN:   state_in = S_MUL;
         S_MUL:    state_in = S_WR_SQ;
         S_WR_SQ:  state_in = S_IDLE;
         S_SQRT:   if (status.sqrt_done) state_in = S_OUT;
         S_OUT:    if (!status.rsp_busy) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.clear      = (state_ff == S_CLEAR);
      cmd.load_req   = (state_ff == S_IDLE) && req_valid;
      cmd.mem_rd     = (state_ff == S_READ);
      cmd.wr_sum     = (state_ff == S_WR_SUM);
      cmd.div_start  = (state_ff == S_DECIDE);
      cmd.div_step   = (state_ff == S_DIV);
      cmd.mean_load  = (state_ff == S_MEAN);
      cmd.mul_load   = (state_ff == S_MUL);
      cmd.wr_sq      = (state_ff == S_WR_SQ);
      cmd.sqrt_start = (state_ff == S_DIV) && status.div_done;
      cmd.sqrt_step  = (state_ff == S_SQRT);
      cmd.load_rsp   = (state_ff == S_OUT) && !status.rsp_busy;
   end

   assign req_stall = (state_ff != S_IDLE);

   `PCSD_ASSERT_NEXT(a_wr_sum_done, clock, reset, state_ff == S_WR_SUM, state_ff == S_IDLE)
   `PCSD_ASSERT_NEXT(a_div_exit, clock, reset, (state_ff == S_DIV) && status.div_done,
                     (state_ff == S_MEAN) || (state_ff == S_SQRT))
   `PCSD_ASSERT_NEXT(a_clear_holds, clock, reset,
                     (state_ff == S_CLEAR) && !status.clear_last, state_ff == S_CLEAR)
   `PCSD_ASSERT_IMPL(a_rsp_only_out, clock, reset, cmd.load_rsp, state_ff == S_OUT)

endmodule

// ----- hw/rtl/pcsd_datapath.sv -----
// ----------------------------------------------------------------------------
// pcsd_datapath
// Cell stores, shared radix-2 divider, integer square root and output register.
// ----------------------------------------------------------------------------
module pcsd_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  pcsd_pkg::cmd_type             cmd,
   output pcsd_pkg::status_type          status,
   input  logic                          csr_write,
   input  logic [pcsd_pkg::IDX_W-1:0]    csr_index,
   input  logic [pcsd_pkg::VAL_W-1:0]    csr_data,
   input  logic [1:0]                    req_op,
   input  logic [pcsd_pkg::CELL_W-1:0]   req_cell_req,
   input  logic signed [pcsd_pkg::VAL_W-1:0] req_sample,
   input  logic signed [pcsd_pkg::VAL_W-1:0] req_missing_marker,
   input  logic signed [pcsd_pkg::VAL_W-1:0] req_bad_marker,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pcsd_pkg::CELL_W-1:0]   rsp_out_cell,
   output logic signed [pcsd_pkg::VAL_W-1:0] rsp_std_dev,
   output logic [1:0]                    rsp_status
);
   import pcsd_pkg::*;

   // configuration
   logic                    incl_ff;
   logic signed [VAL_W-1:0] subst_ff, omiss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         incl_ff  <= 1'b0;
         subst_ff <= '0;
         omiss_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_INCLUDE_MISSING: incl_ff  <= csr_data[0];
            REG_SUBSTITUTE:      subst_ff <= csr_data;
            REG_OUT_MISSING:     omiss_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // captured request
   logic [1:0]              op_ff;
   logic [CELL_W-1:0]       cell_ff;
   logic signed [VAL_W-1:0] x_ff;
   logic                    skip_ff;
   logic                    marker;

   assign marker = (req_sample == req_missing_marker) || (req_sample == req_bad_marker);

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_op;
         cell_ff <= req_cell_req;
         x_ff    <= marker ? subst_ff : req_sample;
         skip_ff <= marker && !incl_ff;
      end
   end

   // cell stores and clearing sweep
   logic signed [SUM_W-1:0] sum_mem [CELLS];
   logic [CNT_W-1:0]        cnt_mem [CELLS];
   logic [SQ_W-1:0]         sq_mem  [CELLS];
   logic signed [SUM_W-1:0] rd_sum_ff;
   logic [CNT_W-1:0]        rd_cnt_ff;
   logic [SQ_W-1:0]         rd_sq_ff;
   logic [CELL_W-1:0]       clr_addr_ff;
   logic [SQ_W-1:0]         prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   logic signed [SUM_W:0]   sum_add;
   logic signed [SUM_W-1:0] sum_new;
   logic [CNT_W-1:0]        cnt_new;
   logic [SQ_W:0]           sq_add;
   logic [SQ_W-1:0]         sq_new;

   always_comb begin
      sum_add = {rd_sum_ff[SUM_W-1], rd_sum_ff} + (SUM_W+1)'(x_ff);
      if (sum_add[SUM_W] != sum_add[SUM_W-1]) begin
         sum_new = sum_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_new = sum_add[SUM_W-1:0];
      end
      cnt_new = (&rd_cnt_ff) ? rd_cnt_ff : rd_cnt_ff + 1'b1;
      sq_add  = {1'b0, rd_sq_ff} + {1'b0, prod_ff};
      sq_new  = sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         sum_mem[clr_addr_ff] <= '0;
         cnt_mem[clr_addr_ff] <= '0;
         sq_mem[clr_addr_ff]  <= '0;
      end else begin
         if (cmd.wr_sum) begin
            sum_mem[cell_ff] <= sum_new;
            cnt_mem[cell_ff] <= cnt_new;
         end
         if (cmd.wr_sq) begin
            sq_mem[cell_ff] <= sq_new;
         end
      end
      if (cmd.mem_rd) begin
         rd_sum_ff <= sum_mem[cell_ff];
         rd_cnt_ff <= cnt_mem[cell_ff];
         rd_sq_ff  <= sq_mem[cell_ff];
      end
   end

   // restoring divider, one quotient bit a cycle
   logic [SQ_W-1:0]        div_q_ff;
   logic [CNT_W-1:0]       div_r_ff, div_d_ff;
   logic [5:0]             div_cnt_ff;
   logic                   neg_ff;
   logic [SUM_W-1:0]       sum_mag;
   logic [CNT_W:0]         rem_sh, rem_sub;
   logic                   rem_ge;

   assign sum_mag = rd_sum_ff[SUM_W-1] ? SUM_W'(-rd_sum_ff) : SUM_W'(rd_sum_ff);
   assign rem_sh  = {div_r_ff, div_q_ff[SQ_W-1]};
   assign rem_ge  = rem_sh >= {1'b0, div_d_ff};
   assign rem_sub = rem_sh - {1'b0, div_d_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_q_ff   <= (op_ff == OP_DEV) ? SQ_W'(sum_mag) : rd_sq_ff;
         div_d_ff   <= (op_ff == OP_DEV) ? rd_cnt_ff : rd_cnt_ff - 1'b1;
         div_r_ff   <= '0;
         div_cnt_ff <= '0;
         neg_ff     <= rd_sum_ff[SUM_W-1];
      end else if (cmd.div_step) begin
         div_q_ff   <= {div_q_ff[SQ_W-2:0], rem_ge};
         div_r_ff   <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   // mean clamp, then squared deviation
   logic signed [VAL_W-1:0] mean_ff;
   logic [SUM_W-1:0]        q_mag;

   assign q_mag = div_q_ff[SUM_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.mean_load) begin
         if (!neg_ff && q_mag > SUM_W'(32'h7FFF_FFFF)) begin
            mean_ff <= 32'sh7FFF_FFFF;
         end else if (neg_ff && q_mag > SUM_W'(33'h0_8000_0000)) begin
            mean_ff <= 32'sh8000_0000;
         end else begin
            mean_ff <= neg_ff ? VAL_W'(-q_mag) : q_mag[VAL_W-1:0];
         end
      end
   end

   logic signed [VAL_W+1:0] diff;
   logic [VAL_W+1:0]        dmag;

   assign diff = {{2{x_ff[VAL_W-1]}}, x_ff} - {{2{mean_ff[VAL_W-1]}}, mean_ff};
   assign dmag = diff[VAL_W+1] ? (VAL_W+2)'(-diff) : (VAL_W+2)'(diff);

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         prod_ff <= (|dmag[VAL_W+1:VAL_W]) ? '1 : dmag[VAL_W-1:0] * dmag[VAL_W-1:0];
      end
   end

   // integer square root, one result bit a cycle
   logic [SQ_W-1:0]    sq_v_ff;
   logic [VAL_W-1:0]   root_ff;
   logic [VAL_W+1:0]   srem_ff, srem_sh, trial;
   logic [4:0]         sq_cnt_ff;
   logic               sq_ge;

   assign srem_sh = {srem_ff[VAL_W-1:0], sq_v_ff[SQ_W-1:SQ_W-2]};
   assign trial   = {root_ff, 2'b01};
   assign sq_ge   = srem_sh >= trial;

   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         sq_v_ff   <= {div_q_ff[SQ_W-2:0], rem_ge};
         root_ff   <= '0;
         srem_ff   <= '0;
         sq_cnt_ff <= '0;
      end else if (cmd.sqrt_step) begin
         sq_v_ff   <= {sq_v_ff[SQ_W-3:0], 2'b00};
         root_ff   <= {root_ff[VAL_W-2:0], sq_ge};
         srem_ff   <= sq_ge ? srem_sh - trial : srem_sh;
         sq_cnt_ff <= sq_cnt_ff + 1'b1;
      end
   end

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]       rsp_cell_ff;
   logic signed [VAL_W-1:0] rsp_sd_ff;
   logic [1:0]              rsp_stat_ff;

   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_cell_ff <= cell_ff;
         if (rd_cnt_ff == '0) begin
            rsp_sd_ff   <= omiss_ff;
            rsp_stat_ff <= STAT_EMPTY;
         end else if (rd_cnt_ff == CNT_W'(1)) begin
            rsp_sd_ff   <= '0;
            rsp_stat_ff <= STAT_SINGLE;
         end else begin
            rsp_sd_ff   <= root_ff[VAL_W-1] ? 32'sh7FFF_FFFF : root_ff;
            rsp_stat_ff <= STAT_OK;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_cell = rsp_cell_ff;
   assign rsp_std_dev  = rsp_sd_ff;
   assign rsp_status   = rsp_stat_ff;

   always_comb begin
      status            = '0;
      status.op         = op_ff;
      status.skip       = skip_ff;
      status.cnt_zero   = (rd_cnt_ff == '0);
      status.cnt_one    = (rd_cnt_ff == CNT_W'(1));
      status.div_done   = (div_cnt_ff == '1);
      status.sqrt_done  = (sq_cnt_ff == '1);
      status.clear_last = (clr_addr_ff == '1);
      status.rsp_busy   = rsp_valid_ff & rsp_stall;
   end

endmodule

// ----- hw/rtl/per_cell_standard_deviation_top.sv -----
// ----------------------------------------------------------------------------
// per_cell_standard_deviation_top
// Two-pass per-cell sample standard deviation over a stack of Q16.16 grids.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transfer (valid high, stall low): op 0 folds a
//   sample into the cell sum and count, op 1 folds its squared deviation from
//   the cell mean, op 2 reads the cell out. Only op 2 produces an rsp_*
//   transfer. csr_* writes include_missing, substitute_value and
//   output_missing_value; write them only while the block is idle.
//   One item is worked on at a time. Op 0 reads, decides and writes the sum;
//   op 1 runs a 64-step shared divider for the mean, then mean clamp, multiply
//   and write back; op 2 runs the divider for the variance, then a 32-step
//   square root, or skips both for an empty or single cell.
//   The result sits in an output register; a new item is accepted while it
//   waits, and a further readout holds until rsp_stall drops.
//   After reset a clearing pass zeroes all 4096 cells, one per cycle, and
//   req_stall stays high until the pass ends.
// ----------------------------------------------------------------------------
module per_cell_standard_deviation_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [pcsd_pkg::IDX_W-1:0]        csr_index,
   input  logic [pcsd_pkg::VAL_W-1:0]        csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_op,
   input  logic [pcsd_pkg::CELL_W-1:0]       req_cell_req,
   input  logic signed [pcsd_pkg::VAL_W-1:0] req_sample,
   input  logic signed [pcsd_pkg::VAL_W-1:0] req_missing_marker,
   input  logic signed [pcsd_pkg::VAL_W-1:0] req_bad_marker,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pcsd_pkg::CELL_W-1:0]       rsp_out_cell,
   output logic signed [pcsd_pkg::VAL_W-1:0] rsp_std_dev,
   output logic [1:0]                        rsp_status
);
   import pcsd_pkg::*;

   cmd_type    cmd;
   status_type status;

   pcsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pcsd_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_op             (req_op),
      .req_cell_req       (req_cell_req),
      .req_sample         (req_sample),
      .req_missing_marker (req_missing_marker),
      .req_bad_marker     (req_bad_marker),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_cell       (rsp_out_cell),
      .rsp_std_dev        (rsp_std_dev),
      .rsp_status         (rsp_status)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the per-cell standard deviation block: a directed
// table, then two-pass stacks with random content under several register
// settings, each readout compared with a cycle-free software copy or a typed value.
// ----------------------------------------------------------------------------
module tb_top;
   import pcsd_pkg::*;

   localparam int    IDLE_LIMIT  = 20000;
   localparam int    SETTLE      = 150;
   localparam longint SUM_HI     = 64'sd549755813887;
   localparam longint SUM_LO     = -64'sd549755813888;

   typedef struct {
      logic [CELL_W-1:0] cell_idx;
      logic [VAL_W-1:0]  sd;
      logic [1:0]        status;
   } readout_type;

   typedef struct {
      logic [1:0]        op;
      logic [CELL_W-1:0] cell_idx;
      logic [VAL_W-1:0]  sample;
      logic [VAL_W-1:0]  mm;
      logic [VAL_W-1:0]  bm;
      bit                typed;
      logic [VAL_W-1:0]  sd;
      logic [1:0]        status;
   } row_type;

   logic                     clock = 0;
   logic                     reset;
   logic                     csr_write;
   logic [IDX_W-1:0]         csr_index;
   logic [VAL_W-1:0]         csr_data;
   logic                     req_valid;
   logic                     req_stall;
   logic [1:0]               req_op;
   logic [CELL_W-1:0]        req_cell_req;
   logic signed [VAL_W-1:0]  req_sample;
   logic signed [VAL_W-1:0]  req_missing_marker;
   logic signed [VAL_W-1:0]  req_bad_marker;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [CELL_W-1:0]        rsp_out_cell;
   logic signed [VAL_W-1:0]  rsp_std_dev;
   logic [1:0]               rsp_status;

   // typed expectation travelling with the request
   bit                       typed_on;
   logic [VAL_W-1:0]         typed_sd;
   logic [1:0]               typed_status;

   longint                   sum_m [CELLS];
   int unsigned              cnt_m [CELLS];
   logic [63:0]              sq_m  [CELLS];
   bit                       inc_m;
   logic signed [VAL_W-1:0]  subst_m;
   logic signed [VAL_W-1:0]  outmiss_m;

   readout_type              readout_q[$];
   int                       errors;
   int                       idle_cycles;
   bit                       hold_req;
   bit                       calm_tx;

   per_cell_standard_deviation_top dut (.*);

   always #2 clock = ~clock;

   task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
      $display("MISMATCH %s: expected %h got %h at %0t", what, want, got, $realtime);
      errors++;
   endtask

   function automatic logic [63:0] isqrt(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // marker hits are dropped or swapped for the substitute
   function automatic bit pick_value(input logic [31:0] s, input logic [31:0] mm,
                                     input logic [31:0] bm, output longint x);
      if (s == mm || s == bm) begin
         x = longint'(subst_m);
         return inc_m;
      end
      x = longint'($signed(s));
      return 1;
   endfunction

   function automatic bit fold_item(input logic [1:0] op, input logic [CELL_W-1:0] c,
                                    input logic [31:0] s, input logic [31:0] mm,
                                    input logic [31:0] bm, output readout_type r);
      longint      x, acc_s, mean, diff, mag;
      logic [63:0] sq, m64, dv;
      logic [64:0] acc;
      r.cell_idx = c;
      if (op == OP_SUM) begin
         if (!pick_value(s, mm, bm, x)) return 0;
         acc_s = sum_m[c] + x;
         if (acc_s > SUM_HI) acc_s = SUM_HI;
         if (acc_s < SUM_LO) acc_s = SUM_LO;
         sum_m[c] = acc_s;
         if (cnt_m[c] < 511) cnt_m[c]++;
         return 0;
      end
      if (op == OP_DEV) begin
         if (cnt_m[c] == 0 || !pick_value(s, mm, bm, x)) return 0;
         mean = sum_m[c] / longint'(cnt_m[c]);
         if (mean > 64'sh7FFF_FFFF) mean = 64'sh7FFF_FFFF;
         if (mean < -64'sh8000_0000) mean = -64'sh8000_0000;
         diff = x - mean;
         mag = diff < 0 ? -diff : diff;
         m64 = mag;
         sq = (m64 >= 64'h1_0000_0000) ? '1 : m64 * m64;
         acc = {1'b0, sq_m[c]} + {1'b0, sq};
         sq_m[c] = acc[64] ? '1 : acc[63:0];
         return 0;
      end
      if (op == OP_READ) begin
         if (cnt_m[c] == 0) begin
            r.sd = outmiss_m;
            r.status = STAT_EMPTY;
         end else if (cnt_m[c] == 1) begin
            r.sd = 0;
            r.status = STAT_SINGLE;
         end else begin
            dv = cnt_m[c] - 1;
            m64 = isqrt(sq_m[c] / dv);
            r.sd = (m64 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m64[31:0];
            r.status = STAT_OK;
         end
         return 1;
      end
      return 0;
   endfunction

   // monitor: register writes, request and response transfers, watchdog
   always @(posedge clock) begin
      readout_type r;
      readout_type w;
      bit moved;
      moved = 0;
      if (!reset) begin
         if (csr_write) begin
            case (csr_index)
               REG_INCLUDE_MISSING: inc_m = csr_data[0];
               REG_SUBSTITUTE:      subst_m = csr_data;
               REG_OUT_MISSING:     outmiss_m = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            moved = 1;
            if (fold_item(req_op, req_cell_req, req_sample, req_missing_marker,
                          req_bad_marker, r)) begin
               if (typed_on) begin
                  r.sd = typed_sd;
                  r.status = typed_status;
               end
               readout_q.push_back(r);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1;
            if (readout_q.size() == 0) begin
               report("unexpected transfer, cell", 0, rsp_out_cell);
            end else begin
               w = readout_q.pop_front();
               if (rsp_out_cell !== w.cell_idx) report("out_cell", w.cell_idx, rsp_out_cell);
               if (rsp_std_dev !== w.sd) report("std_dev", w.sd, rsp_std_dev);
               if (rsp_status !== w.status) report("status", w.status, rsp_status);
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("per_cell_standard_deviation_top test failed");
            $finish;
         end
      end
   end

   // receiver: random stalls, calm stretches, and a long hold on request
   initial begin
      int hold_left;
      int span;
      hold_left = 0;
      span = 0;
      calm_tx = 0;
      rsp_stall = 0;
      forever begin
         @(posedge clock);
         if (span == 0) begin
            calm_tx = ($urandom_range(0, 3) == 0);
            span = 256;
         end
         span--;
         if (hold_req) begin
            hold_req = 0;
            hold_left = 500;
         end
         if (hold_left == 0 && !calm_tx && $urandom_range(0, 49) == 0)
            hold_left = $urandom_range(20, 60);
         if (hold_left > 0) begin
            rsp_stall <= 1;
            hold_left--;
         end else begin
            rsp_stall <= calm_tx ? 1'b0 : ($urandom_range(0, 3) == 0);
         end
      end
   end

   function automatic int pick_gap(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send(input row_type it, input int gap);
      req_valid          <= 1;
      req_op             <= it.op;
      req_cell_req       <= it.cell_idx;
      req_sample         <= it.sample;
      req_missing_marker <= it.mm;
      req_bad_marker     <= it.bm;
      typed_on           <= it.typed;
      typed_sd           <= it.sd;
      typed_status       <= it.status;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop valid, wait for outstanding readouts, then let the datapath settle
   task automatic drain();
      req_valid <= 0;
      while (readout_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 0;
   endtask

   function automatic row_type mk(input logic [1:0] op, input logic [CELL_W-1:0] c,
                                  input logic [31:0] s, input logic [31:0] mm,
                                  input logic [31:0] bm);
      row_type it;
      it.op = op; it.cell_idx = c; it.sample = s; it.mm = mm; it.bm = bm;
      it.typed = 0; it.sd = 0; it.status = STAT_OK;
      return it;
   endfunction

   function automatic row_type mk_known(input logic [CELL_W-1:0] c, input logic [31:0] sd,
                                        input logic [1:0] st);
      row_type it;
      it = mk(OP_READ, c, $urandom, $urandom, $urandom);
      it.typed = 1; it.sd = sd; it.status = st;
      return it;
   endfunction

   function automatic logic [31:0] pick_sample(input logic [31:0] base, input logic [31:0] mm,
                                               input logic [31:0] bm);
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return mm;
         4:       return bm;
         default: return base + $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      endcase
   endfunction

   function automatic row_type noise_item();
      return mk(2'($urandom_range(0, 3)), CELL_W'($urandom), $urandom, $urandom, $urandom);
   endfunction

   // one two-pass stack: sums, deviations with the same samples, readouts, plus noise items
   task automatic run_stack(input int fields, input int cells);
      logic [CELL_W-1:0] cl [4];
      logic [31:0]       sv [8][4];
      logic [31:0]       mv [8];
      logic [31:0]       bv [8];
      logic [31:0]       base;
      bit                calm;
      calm = ($urandom_range(0, 4) == 0);
      base = $urandom;
      for (int c = 0; c < cells; c++) cl[c] = CELL_W'($urandom);
      for (int f = 0; f < fields; f++) begin
         mv[f] = $urandom;
         bv[f] = $urandom;
         for (int c = 0; c < cells; c++) sv[f][c] = pick_sample(base, mv[f], bv[f]);
      end
      for (int p = 0; p < 2; p++)
         for (int f = 0; f < fields; f++)
            for (int c = 0; c < cells; c++) begin
               if ($urandom_range(0, 19) == 0) send(noise_item(), pick_gap(calm));
               send(mk(p == 0 ? OP_SUM : OP_DEV, cl[c], sv[f][c], mv[f], bv[f]),
                    pick_gap(calm));
            end
      for (int c = 0; c < cells; c++)
         send(mk(OP_READ, cl[c], $urandom, $urandom, $urandom), pick_gap(calm));
   endtask

   row_type table_rows [$];

   initial begin
      row_type t;
      errors = 0;
      idle_cycles = 0;
      hold_req = 0;
      inc_m = 0;
      subst_m = 0;
      outmiss_m = 0;
      for (int i = 0; i < CELLS; i++) begin
         sum_m[i] = 0;
         cnt_m[i] = 0;
         sq_m[i] = 0;
      end
      reset = 1;
      csr_write = 0;
      csr_index = 0;
      csr_data = 0;
      req_valid = 0;
      req_op = 0;
      req_cell_req = 0;
      req_sample = 0;
      req_missing_marker = 0;
      req_bad_marker = 0;
      typed_on = 0;
      typed_sd = 0;
      typed_status = 0;
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed table, default registers
      table_rows.push_back(mk_known(0, 0, STAT_EMPTY));
      table_rows.push_back(mk_known(12'hFFF, 0, STAT_EMPTY));
      table_rows.push_back(mk(OP_SUM, 12'hFFF, 32'h7FFF_FFFF, 0, 1));
      table_rows.push_back(mk_known(12'hFFF, 0, STAT_SINGLE));
      table_rows.push_back(mk(OP_SUM, 12'hFFF, 32'h8000_0000, 0, 1));
      table_rows.push_back(mk(OP_DEV, 12'hFFF, 32'h7FFF_FFFF, 0, 1));
      table_rows.push_back(mk(OP_DEV, 12'hFFF, 32'h8000_0000, 0, 1));
      table_rows.push_back(mk(OP_READ, 12'hFFF, 0, 0, 0));
      table_rows.push_back(mk(OP_SUM, 12'h555, 32'h1234_0000, 32'h1234_0000, 0));
      table_rows.push_back(mk(OP_SUM, 12'h555, 32'hDEAD_0000, 0, 32'hDEAD_0000));
      table_rows.push_back(mk_known(12'h555, 0, STAT_EMPTY));
      table_rows.push_back(mk(OP_DEV, 12'hAAA, 32'h0001_0000, 0, 0));
      table_rows.push_back(mk_known(12'hAAA, 0, STAT_EMPTY));
      table_rows.push_back(mk(2'd3, 12'hAAA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      table_rows.push_back(mk_known(12'hAAA, 0, STAT_EMPTY));
      table_rows.push_back(mk(OP_SUM, 12'h00F, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      table_rows.push_back(mk(OP_SUM, 12'h00F, 32'h0003_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      table_rows.push_back(mk(OP_DEV, 12'h00F, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      table_rows.push_back(mk(OP_DEV, 12'h00F, 32'h0003_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      table_rows.push_back(mk(OP_READ, 12'h00F, 0, 0, 0));
      foreach (table_rows[i]) send(table_rows[i], pick_gap(0));
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               write_reg(REG_INCLUDE_MISSING, 0);
               write_reg(REG_SUBSTITUTE, 32'h7FFF_FFFF);
               write_reg(REG_OUT_MISSING, 32'h7FFF_FFFF);
            end
            1: begin
               write_reg(REG_INCLUDE_MISSING, 1);
               write_reg(REG_SUBSTITUTE, 32'h8000_0000);
               write_reg(REG_OUT_MISSING, 32'h8000_0000);
            end
            2: begin
               write_reg(REG_SUBSTITUTE, 32'h7FFF_FFFF);
               write_reg(REG_OUT_MISSING, $urandom);
            end
            default: begin
               write_reg(REG_INCLUDE_MISSING, VAL_W'($urandom_range(0, 1)));
               write_reg(REG_SUBSTITUTE, $urandom);
               write_reg(REG_OUT_MISSING, $urandom);
            end
         endcase
         if (ph == 1) begin
            // hold the receiver while readouts pile up behind it
            hold_req = 1;
            for (int i = 0; i < 12; i++)
               send(mk(OP_READ, CELL_W'($urandom), 0, 0, 0), 0);
         end
         if (ph == 2) begin
            // push one cell past the count and sum limits
            t = mk(OP_SUM, CELL_W'($urandom), 32'h7FFF_FFFF, 0, 0);
            repeat (515) send(t, 0);
            t.op = OP_DEV;
            repeat (3) send(t, 0);
            t.op = OP_READ;
            send(t, 0);
         end
         for (int k = 0; k < 9; k++) begin
            if (ph == 3 && k == 4) begin
               req_valid <= 0;
               while (readout_q.size() != 0) @(posedge clock);
            end
            run_stack($urandom_range(1, 8), $urandom_range(1, 4));
         end
         drain();
      end

      if (readout_q.size() != 0) report("readouts left over", 0, readout_q.size());
      if (errors == 0) begin
         $display("per_cell_standard_deviation_top test passed");
      end else begin
         $display("per_cell_standard_deviation_top test failed");
      end
      $finish;
   end

endmodule
